// ===== sv/bmq_pkg.sv =====
// shared types and constants for the bus message queue block
package bmq_pkg;

  localparam int unsigned WORD_W = 64;
  localparam int unsigned CMD_W  = 3;
  localparam int unsigned TYPE_W = 2;
  localparam int unsigned CAP_W  = 5;

  localparam logic [CMD_W-1:0] CMD_PUSH_TX     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_RX     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK_RX     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_RX      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ROLLBACK_TX = 3'd4;
  localparam logic [CMD_W-1:0] CMD_DRAIN_TX    = 3'd5;

  localparam logic [1:0] SEL_REQ  = 2'd0;
  localparam logic [1:0] SEL_RSP  = 2'd1;
  localparam logic [1:0] SEL_NONE = 2'd2;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] cyc;
    logic [WORD_W-1:0] body;
  } ent_t;

  typedef struct packed {
    logic found;
    ent_t ent;
  } link_t;

  typedef struct packed {
    logic              use_match;
    logic [WORD_W-1:0] key;
    logic [WORD_W-1:0] mask;
  } srch_t;

endpackage

// ===== sv/bmq_in_if.sv =====
// command channel interface
interface bmq_in_if;
  logic                           valid;
  logic                           ready;
  logic [bmq_pkg::CMD_W-1:0]      command;
  logic [bmq_pkg::TYPE_W-1:0]     msg_type;
  logic [bmq_pkg::WORD_W-1:0]     msg_addr;
  logic [bmq_pkg::WORD_W-1:0]     msg_cycle;
  logic [bmq_pkg::WORD_W-1:0]     msg_payload;
  logic [bmq_pkg::WORD_W-1:0]     stamp_cycle;
  logic [bmq_pkg::WORD_W-1:0]     line_size;

  modport source (output valid, command, msg_type, msg_addr, msg_cycle, msg_payload,
                  stamp_cycle, line_size, input ready);
  modport sink (input valid, command, msg_type, msg_addr, msg_cycle, msg_payload,
                stamp_cycle, line_size, output ready);
endinterface

// ===== sv/bmq_out_if.sv =====
// result channel interface
interface bmq_out_if;
  logic                       valid;
  logic                       ready;
  logic                       ok;
  logic                       out_type;
  logic [bmq_pkg::WORD_W-1:0] out_addr;
  logic [bmq_pkg::WORD_W-1:0] out_cycle;
  logic [bmq_pkg::WORD_W-1:0] out_payload;

  modport source (output valid, ok, out_type, out_addr, out_cycle, out_payload,
                  input ready);
  modport sink (input valid, ok, out_type, out_addr, out_cycle, out_payload,
                output ready);
endinterface

// ===== sv/bmq_cell.sv =====
// one queue slot: holds an entry, matches, and shifts down from its neighbor
module bmq_cell (
  input  logic            clk,
  input  bmq_pkg::srch_t  srch,
  input  logic            cand,
  input  logic            rem_en,
  input  logic            wr_en,
  input  bmq_pkg::ent_t   wr_ent,
  input  bmq_pkg::ent_t   nxt_ent,
  input  bmq_pkg::link_t  link_in,
  output bmq_pkg::link_t  link_out,
  output bmq_pkg::ent_t   ent
);
  bmq_pkg::ent_t ent_r, ent_nxt;
  logic match, take;

  always_comb begin
    match = ((ent_r.addr ^ srch.key) & srch.mask) == '0;
    take  = cand & ~link_in.found & (~srch.use_match | match);
    link_out.found = link_in.found | take;
    link_out.ent   = take ? ent_r : link_in.ent;
    if (wr_en) begin
      ent_nxt = wr_ent;
    end else if (rem_en && link_out.found) begin
      ent_nxt = nxt_ent;
    end else begin
      ent_nxt = ent_r;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign ent = ent_r;
endmodule

// ===== sv/bmq_queue.sv =====
// one bounded queue built as a row of cells with a fill count
module bmq_queue #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CW    = $clog2(DEPTH + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bmq_pkg::srch_t  srch,
  input  logic            push_en,
  input  bmq_pkg::ent_t   push_ent,
  input  logic            rem_en,
  output logic [CW-1:0]   count,
  output logic            found,
  output bmq_pkg::ent_t   hit
);
  bmq_pkg::link_t lk [DEPTH+1];
  bmq_pkg::ent_t  ents [DEPTH];
  logic [CW-1:0]  count_r, count_nxt;

  assign lk[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic          cand, wr;
    bmq_pkg::ent_t nxt;
    assign cand = (CW'(i) < count_r) & (srch.use_match | (i == 0));
    assign wr   = push_en & (count_r == CW'(i));
    if (i == DEPTH - 1) begin : g_last
      assign nxt = ents[i];
    end else begin : g_mid
      assign nxt = ents[i+1];
    end
    bmq_cell u_cell (
      .clk      (clk),
      .srch     (srch),
      .cand     (cand),
      .rem_en   (rem_en),
      .wr_en    (wr),
      .wr_ent   (push_ent),
      .nxt_ent  (nxt),
      .link_in  (lk[i]),
      .link_out (lk[i+1]),
      .ent      (ents[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (push_en) begin
      count_nxt = count_r + CW'(1);
    end else if (rem_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign count = count_r;
  assign found = lk[DEPTH].found;
  assign hit   = lk[DEPTH].ent;
endmodule

// ===== sv/bus_message_queues_rollback_unit.sv =====
// Four bounded message queues (tx request/response, rx request/response) behind one
// command channel. Each queue is a row of QUEUE_DEPTH cells with a fill count. A command
// is accepted only while the block is idle and enters execution in the following cycle,
// where, for a tx rollback, every cell compares its address under the line mask in
// parallel (other commands take only the head cell), a found flag ripples down the row
// to pick the first hit, and on removal the cells behind the hit shift down by one. The
// result is registered when execution ends, and the block is idle again from then on. A
// result beat that is not yet taken holds the following command in execution, which in
// turn holds off the input. Every command gives exactly one result beat.
module bus_message_queues_rollback_unit #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [bmq_pkg::CAP_W-1:0]    cfg_wdata,
  bmq_in_if.sink                       in_bus,
  bmq_out_if.source                    out_bus
);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned LW = (CW > bmq_pkg::CAP_W) ? CW : bmq_pkg::CAP_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;
  logic [bmq_pkg::CAP_W-1:0]  cap_r;
  logic [1:0]                 sel_r, sel_nxt;
  logic [bmq_pkg::CMD_W-1:0]  cmd_r;
  logic [bmq_pkg::TYPE_W-1:0] type_r;
  bmq_pkg::ent_t              msg_r;
  logic [bmq_pkg::WORD_W-1:0] mask_r;

  logic                       out_valid_r, ok_r, ok_nxt, otype_r, otype_nxt;
  bmq_pkg::ent_t              oent_r, oent_nxt;

  logic [CW-1:0]  cnt [4];
  logic           fnd [4];
  bmq_pkg::ent_t  hit [4];
  logic [3:0]     push_en, rem_en;
  bmq_pkg::srch_t srch;
  logic           go, acc;

  assign acc = in_bus.valid & in_bus.ready;
  assign in_bus.ready = (state_r == ST_IDLE);
  assign go = (state_r == ST_EXEC) & (~out_valid_r | out_bus.ready);

  assign srch.use_match = (cmd_r == bmq_pkg::CMD_ROLLBACK_TX);
  assign srch.key       = msg_r.addr;
  assign srch.mask      = mask_r;

  for (genvar q = 0; q < 4; q++) begin : g_q
    bmq_queue #(.DEPTH(QUEUE_DEPTH), .CW(CW)) u_queue (
      .clk      (clk),
      .rst_n    (rst_n),
      .srch     (srch),
      .push_en  (push_en[q]),
      .push_ent (msg_r),
      .rem_en   (rem_en[q]),
      .count    (cnt[q]),
      .found    (fnd[q]),
      .hit      (hit[q])
    );
  end

  always_comb begin
    logic [1:0] qi;
    logic       full, rq, rs;
    push_en   = '0;
    rem_en    = '0;
    sel_nxt   = sel_r;
    ok_nxt    = 1'b0;
    otype_nxt = 1'b0;
    oent_nxt  = '0;
    qi        = {cmd_r == bmq_pkg::CMD_PUSH_RX, type_r[0]};
    full      = (LW'(cnt[qi]) >= LW'(cap_r)) || (LW'(cnt[qi]) >= LW'(QUEUE_DEPTH));
    rq        = cnt[2] != '0;
    rs        = cnt[3] != '0;
    case (cmd_r)
      bmq_pkg::CMD_PUSH_TX, bmq_pkg::CMD_PUSH_RX: begin
        if (!type_r[1] && !full) begin
          push_en[qi] = go;
          ok_nxt      = 1'b1;
          otype_nxt   = type_r[0];
          oent_nxt    = msg_r;
        end
      end
      bmq_pkg::CMD_PEEK_RX: begin
        if (sel_r == bmq_pkg::SEL_REQ) begin
          sel_nxt = rs ? bmq_pkg::SEL_RSP : (rq ? bmq_pkg::SEL_REQ : bmq_pkg::SEL_NONE);
        end else begin
          sel_nxt = rq ? bmq_pkg::SEL_REQ : (rs ? bmq_pkg::SEL_RSP : bmq_pkg::SEL_NONE);
        end
        if (sel_nxt != bmq_pkg::SEL_NONE) begin
          ok_nxt    = 1'b1;
          otype_nxt = sel_nxt[0];
          oent_nxt  = hit[{1'b1, sel_nxt[0]}];
        end
      end
      bmq_pkg::CMD_POP_RX: begin
        if (!sel_r[1] && fnd[{1'b1, sel_r[0]}]) begin
          rem_en[{1'b1, sel_r[0]}] = go;
          ok_nxt    = 1'b1;
          otype_nxt = sel_r[0];
          oent_nxt  = hit[{1'b1, sel_r[0]}];
        end
      end
      bmq_pkg::CMD_ROLLBACK_TX: begin
        if (fnd[0]) begin
          rem_en[0] = go;
          ok_nxt    = 1'b1;
          oent_nxt  = hit[0];
        end else if (fnd[1]) begin
          rem_en[1] = go;
          ok_nxt    = 1'b1;
          otype_nxt = 1'b1;
          oent_nxt  = hit[1];
        end
      end
      bmq_pkg::CMD_DRAIN_TX: begin
        if (!type_r[1] && fnd[{1'b0, type_r[0]}]) begin
          rem_en[{1'b0, type_r[0]}] = go;
          ok_nxt    = 1'b1;
          otype_nxt = type_r[0];
          oent_nxt  = hit[{1'b0, type_r[0]}];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc) state_nxt = ST_EXEC;
      ST_EXEC: if (go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= bmq_pkg::CAP_RESET;
      sel_r       <= bmq_pkg::SEL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      if (go && cmd_r == bmq_pkg::CMD_PEEK_RX) sel_r <= sel_nxt;
      if (go) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cmd_r     <= in_bus.command;
      type_r    <= in_bus.msg_type;
      msg_r.addr <= in_bus.msg_addr;
      msg_r.cyc <= (in_bus.command == bmq_pkg::CMD_PUSH_TX && in_bus.stamp_cycle != '0) ?
                   in_bus.stamp_cycle : in_bus.msg_cycle;
      msg_r.body <= in_bus.msg_payload;
      mask_r    <= ~(in_bus.line_size - bmq_pkg::WORD_W'(1));
    end
    if (go) begin
      ok_r    <= ok_nxt;
      otype_r <= otype_nxt;
      oent_r  <= oent_nxt;
    end
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.ok          = ok_r;
  assign out_bus.out_type    = otype_r;
  assign out_bus.out_addr    = oent_r.addr;
  assign out_bus.out_cycle   = oent_r.cyc;
  assign out_bus.out_payload = oent_r.body;
endmodule
